// ----- hdl/erate_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder rate estimator package
// Shared types, command codes, register indexes and datapath widths for the
// bit-serial encoder rate estimator.
// ----------------------------------------------------------------------------
package erate_pkg;

   // Fixed field widths
   localparam int CNT_W  = 16;
   localparam int CFG17_W = 17;
   localparam int WORD_W = 32;

   // Serial multiplier: multiplicand/product width and multiplier width
   localparam int MUL_A_W = 84;
   localparam int MUL_B_W = 32;

   // Serial divider width
   localparam int DIV_W = 32;

   // Constants of the rate computation
   localparam logic [MUL_B_W-1:0] US_PER_SECOND = 32'd1000000;
   localparam logic [CFG17_W-1:0] ALPHA_ONE     = 17'd65536;
   localparam logic [WORD_W-1:0]  RATE_POS_MAX  = 32'h7FFF_FFFF;
   localparam logic [WORD_W-1:0]  RATE_NEG_MAG  = 32'h8000_0000;

   // Configuration register indexes
   localparam logic [1:0] CSR_PULSES_PER_PERIOD = 2'd0;
   localparam logic [1:0] CSR_RADIANS_PER_PULSE = 2'd1;
   localparam logic [1:0] CSR_SMOOTHING_FACTOR  = 2'd2;

   // Reset values of the configuration registers
   localparam logic [CFG17_W-1:0] PPP_RESET = 17'd65536;
   localparam logic [CFG17_W-1:0] SF_RESET  = 17'd65536;

   typedef enum logic [1:0] {
      CMD_WRAP_UP   = 2'd0,
      CMD_WRAP_DOWN = 2'd1,
      CMD_SAMPLE    = 2'd2,
      CMD_RESTART   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PULSE,
      ST_DELTA,
      ST_RATE,
      ST_SCALE,
      ST_DIV,
      ST_EMA,
      ST_SMOOTH,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [CNT_W-1:0]  counter_value;
      logic [WORD_W-1:0] time_us;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pulse_count;
      logic signed [WORD_W-1:0] raw_rate;
      logic signed [WORD_W-1:0] smoothed_rate;
      logic                     time_error;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [MUL_A_W-1:0] mcand;
      logic [MUL_B_W-1:0] mplier;
   } mul_req_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] rem_init;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

endpackage

// ----- hdl/erate_ser_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial shift-add multiplier
// Consumes one multiplier bit per cycle and finishes as soon as the remaining
// multiplier bits are all zero. The product wraps modulo 2^MUL_A_W.
// ----------------------------------------------------------------------------
module erate_ser_mul
   import erate_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  mul_req_type        mul_req,
   output logic               mul_done,
   output logic [MUL_A_W-1:0] mul_prod
);

   logic               run_ff;
   logic [MUL_A_W-1:0] acc_ff;
   logic [MUL_A_W-1:0] mcand_ff;
   logic [MUL_B_W-1:0] mplier_ff;

   // The product is complete once no multiplier bits remain.
   assign mul_done = run_ff && (mplier_ff == '0);
   assign mul_prod = acc_ff;

   // Control: a start takes priority over the completion of a previous run.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else if (mul_req.start) begin
         run_ff <= 1'b1;
      end else if (mul_done) begin
         run_ff <= 1'b0;
      end
   end

   // Datapath: add the shifted multiplicand for each set multiplier bit.
   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         acc_ff    <= '0;
         mcand_ff  <= mul_req.mcand;
         mplier_ff <= mul_req.mplier;
      end else if (run_ff && !mul_done) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[MUL_A_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MUL_B_W-1:1]};
      end
   end

endmodule

// ----- hdl/erate_ser_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial restoring divider
// Divides {rem_init, dividend} by divisor, one quotient bit per cycle. The
// caller guarantees rem_init < divisor, so the quotient fits DIV_W bits.
// ----------------------------------------------------------------------------
module erate_ser_div
   import erate_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  div_req_type      div_req,
   output logic             div_done,
   output logic [DIV_W-1:0] div_quo
);

   localparam int CntW = $clog2(DIV_W + 1);

   logic             run_ff;
   logic [CntW-1:0]  count_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] dsr_ff;
   logic [DIV_W:0]   trial;

   assign div_done = run_ff && (count_ff == '0);
   assign div_quo  = quo_ff;

   // Trial subtraction of the divisor from the shifted partial remainder.
   assign trial = {rem_ff, quo_ff[DIV_W-1]} - {1'b0, dsr_ff};

   // Control: run flag and step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else if (div_req.start) begin
         run_ff   <= 1'b1;
         count_ff <= CntW'(DIV_W);
      end else if (div_done) begin
         run_ff <= 1'b0;
      end else if (run_ff) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   // Datapath: quotient bits shift in where dividend bits shift out.
   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= div_req.rem_init;
         quo_ff <= div_req.dividend;
         dsr_ff <= div_req.divisor;
      end else if (run_ff && !div_done) begin
         if (!trial[DIV_W]) begin
            rem_ff <= trial[DIV_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[DIV_W-2:0], quo_ff[DIV_W-1]};
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

endmodule

// ----- hdl/encoder_rate_estimator_unit.sv -----
`timescale 1ns / 1ps
// Wrap and restart transactions update the state while idle; the next transaction is taken in the following cycle.
// A sample transaction runs from acceptance to result through a bit-serial multiplier,
// which computes up to four products, and a divider, which runs at most once.
// Multiplier runs end early when the remaining operand bits are zero; one sample at a time.
// Synchronous active-high reset clears the state, the handshake and restores register defaults.
// ----------------------------------------------------------------------------
// Encoder rate estimator
// Extends a wrapping encoder counter into a pulse count, derives a Q16.16
// angular rate from successive samples and keeps an exponential average.
// ----------------------------------------------------------------------------
module encoder_rate_estimator_unit
   import erate_pkg::*;
#(
   parameter int COUNTER_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // Response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // Register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // Only the low counter bits that exist in hardware are used.
   localparam int CntUsed = (COUNTER_BITS < CNT_W) ? COUNTER_BITS : CNT_W;
   localparam logic [CNT_W-1:0] CntMask = CNT_W'((33'd1 << CntUsed) - 33'd1);

   state_type            state_ff, state_in;
   logic [CFG17_W-1:0]   ppp_ff, ppp_in;
   logic [WORD_W-1:0]    rpp_ff, rpp_in;
   logic [CFG17_W-1:0]   sf_ff, sf_in;
   logic [WORD_W-1:0]    period_ff, period_in;
   logic [WORD_W-1:0]    last_pulses_ff, last_pulses_in;
   logic [WORD_W-1:0]    last_time_ff, last_time_in;
   logic [WORD_W-1:0]    average_ff, average_in;
   logic [CNT_W-1:0]     counter_ff, counter_in;
   logic [WORD_W-1:0]    now_ff, now_in;
   logic [WORD_W-1:0]    dt_ff, dt_in;
   logic [WORD_W-1:0]    pulses_ff, pulses_in;
   logic                 neg_ff, neg_in;
   logic                 terr_ff, terr_in;
   logic [WORD_W-1:0]    raw_ff, raw_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   mul_req_type          mul_req;
   logic                 mul_done;
   logic [MUL_A_W-1:0]   mul_prod;
   div_req_type          div_req;
   logic                 div_done;
   logic [DIV_W-1:0]     div_quo;

   logic                 accept_req;
   logic                 rsp_free;
   logic [WORD_W-1:0]    pulse_sum;
   logic [WORD_W-1:0]    dpulse;
   logic [WORD_W-1:0]    mag;
   logic [WORD_W-1:0]    limit;
   logic [WORD_W-1:0]    sat_q;
   logic [WORD_W:0]      diff;
   logic [CFG17_W-1:0]   alpha;

   // Shared bit-serial multiplier
   erate_ser_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   // Serial divider for the time normalisation
   erate_ser_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   // Handshake signals.
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept_req = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign csr_ready  = 1'b1;

   // Arithmetic helpers taken from registered values.
   assign pulse_sum = mul_prod[WORD_W-1:0] + {{(WORD_W-CNT_W){1'b0}}, counter_ff};
   assign dpulse    = pulses_ff - last_pulses_ff;
   assign mag       = dpulse[WORD_W-1] ? (32'd0 - dpulse) : dpulse;
   assign limit     = neg_ff ? RATE_NEG_MAG : RATE_POS_MAX;
   assign sat_q     = (div_quo > limit) ? limit : div_quo;
   assign diff      = {raw_ff[WORD_W-1], raw_ff} - {average_ff[WORD_W-1], average_ff};
   assign alpha     = (sf_ff > ALPHA_ONE) ? ALPHA_ONE : sf_ff;

   // Sequencer: next state, register updates and unit requests.
   always_comb begin
      state_in       = state_ff;
      ppp_in         = ppp_ff;
      rpp_in         = rpp_ff;
      sf_in          = sf_ff;
      period_in      = period_ff;
      last_pulses_in = last_pulses_ff;
      last_time_in   = last_time_ff;
      average_in     = average_ff;
      counter_in     = counter_ff;
      now_in         = now_ff;
      dt_in          = dt_ff;
      pulses_in      = pulses_ff;
      neg_in         = neg_ff;
      terr_in        = terr_ff;
      raw_in         = raw_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      mul_req        = '0;
      div_req        = '0;

      // Register writes are to arrive only while the block is idle; the block itself does not enforce this.
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PULSES_PER_PERIOD: ppp_in = csr_wdata[CFG17_W-1:0];
            CSR_RADIANS_PER_PULSE: rpp_in = csr_wdata;
            CSR_SMOOTHING_FACTOR:  sf_in  = csr_wdata[CFG17_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept_req) begin
               case (cmd_type'(req_data.command))
                  CMD_WRAP_UP:   period_in = period_ff + 32'd1;
                  CMD_WRAP_DOWN: period_in = period_ff - 32'd1;
                  CMD_RESTART: begin
                     period_in      = '0;
                     last_pulses_in = '0;
                     average_in     = '0;
                     last_time_in   = req_data.time_us;
                  end
                  CMD_SAMPLE: begin
                     counter_in     = req_data.counter_value & CntMask;
                     now_in         = req_data.time_us;
                     dt_in          = req_data.time_us - last_time_ff;
                     mul_req.start  = 1'b1;
                     mul_req.mcand  = {{(MUL_A_W-WORD_W){1'b0}}, period_ff};
                     mul_req.mplier = {{(MUL_B_W-CFG17_W){1'b0}}, ppp_ff};
                     state_in       = ST_PULSE;
                  end
                  default: ;
               endcase
            end
         end

         // Extended count from period, pulses per period and counter, doubled into pulses.
         ST_PULSE: begin
            if (mul_done) begin
               pulses_in = {pulse_sum[WORD_W-2:0], 1'b0};
               terr_in   = (dt_ff == '0);
               state_in  = ST_DELTA;
            end
         end

         // Pulse delta as sign and magnitude.
         ST_DELTA: begin
            neg_in = dpulse[WORD_W-1];
            if (terr_ff) begin
               raw_in   = '0;
               state_in = ST_EMA;
            end else begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MUL_A_W-WORD_W){1'b0}}, mag};
               mul_req.mplier = rpp_ff;
               state_in       = ST_RATE;
            end
         end

         // Angle product scaled by the microseconds per second.
         ST_RATE: begin
            if (mul_done) begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = {{(MUL_A_W-2*WORD_W){1'b0}}, mul_prod[2*WORD_W-1:0]};
               mul_req.mplier = US_PER_SECOND;
               state_in       = ST_SCALE;
            end
         end

         // Drop twelve fraction bits; saturate when the quotient needs more
         // than 32 bits, otherwise run the divider.
         ST_SCALE: begin
            if (mul_done) begin
               if (mul_prod[83:44] >= {8'd0, dt_ff}) begin
                  raw_in   = neg_ff ? RATE_NEG_MAG : RATE_POS_MAX;
                  state_in = ST_EMA;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.rem_init = mul_prod[75:44];
                  div_req.dividend = mul_prod[43:12];
                  div_req.divisor  = dt_ff;
                  state_in         = ST_DIV;
               end
            end
         end

         // Saturate the magnitude and restore the sign.
         ST_DIV: begin
            if (div_done) begin
               raw_in   = neg_ff ? (32'd0 - sat_q) : sat_q;
               state_in = ST_EMA;
            end
         end

         // Weighted difference for the moving average.
         ST_EMA: begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = {{(MUL_A_W-WORD_W-1){diff[WORD_W]}}, diff};
            mul_req.mplier = {{(MUL_B_W-CFG17_W){1'b0}}, alpha};
            state_in       = ST_SMOOTH;
         end

         // Floor division by 2^16 is an arithmetic shift of the product.
         ST_SMOOTH: begin
            if (mul_done) begin
               average_in     = average_ff + mul_prod[47:16];
               last_pulses_in = pulses_ff;
               last_time_in   = now_ff;
               state_in       = ST_FINISH;
            end
         end

         // Hand the result to the output register once it is free.
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.pulse_count   = pulses_ff;
               rsp_data_in.raw_rate      = raw_ff;
               rsp_data_in.smoothed_rate = average_ff;
               rsp_data_in.time_error    = terr_ff;
               state_in                  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control and architectural state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ppp_ff         <= PPP_RESET;
         rpp_ff         <= '0;
         sf_ff          <= SF_RESET;
         period_ff      <= '0;
         last_pulses_ff <= '0;
         last_time_ff   <= '0;
         average_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         ppp_ff         <= ppp_in;
         rpp_ff         <= rpp_in;
         sf_ff          <= sf_in;
         period_ff      <= period_in;
         last_pulses_ff <= last_pulses_in;
         last_time_ff   <= last_time_in;
         average_ff     <= average_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Working payload registers.
   always_ff @(posedge clock) begin
      counter_ff  <= counter_in;
      now_ff      <= now_in;
      dt_ff       <= dt_in;
      pulses_ff   <= pulses_in;
      neg_ff      <= neg_in;
      terr_ff     <= terr_in;
      raw_ff      <= raw_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
